// ===== rtl/core/twp_pkg.sv =====
package twp_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TICK_W        = 20;
  localparam int unsigned LOOP_W        = 9;
  localparam int unsigned FRAC_DONE_W   = 17;
  localparam int unsigned FRAC_DONE_BITS = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Stream packing
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 120;

  localparam int unsigned TGT_X_LSB  = 0;
  localparam int unsigned TGT_Y_LSB  = 32;
  localparam int unsigned TGT_Z_LSB  = 64;
  localparam int unsigned DUR_LSB    = 96;
  localparam int unsigned LOOP_LSB   = 128;
  localparam int unsigned PP_BIT     = 137;
  localparam int unsigned EASE_BIT   = 138;
  localparam int unsigned TICK_LSB   = 139;

  // Serial unit widths
  localparam int unsigned MUL_AW  = 34;
  localparam int unsigned MUL_BW  = 32;
  localparam int unsigned MUL_PW  = MUL_AW + MUL_BW;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned RAD_W   = 66;
  localparam int unsigned DEN_W   = 32;

  // Item kinds carried in tuser
  localparam logic [IN_USER_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [IN_USER_W-1:0] MODE_START = 2'd1;
  localparam logic [IN_USER_W-1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

endpackage

// ===== rtl/core/twp_mul.sv =====
module twp_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  twp_pkg::mul_req_t                   req_i,
  input  logic signed [twp_pkg::MUL_AW-1:0]   a_i,
  input  logic        [twp_pkg::MUL_BW-1:0]   b_i,
  output logic                                done_o,
  output logic signed [twp_pkg::MUL_PW-1:0]   p_o
);
  import twp_pkg::*;

  logic signed [MUL_PW-1:0] acc_q, mcand_q;
  logic [MUL_BW-1:0]        mplier_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q, done_q;

  // Step counter: one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= {{(MUL_PW-MUL_AW){a_i[MUL_AW-1]}}, a_i};
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== rtl/core/twp_div.sv =====
module twp_div #(
  parameter int unsigned NW = 50
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  twp_pkg::div_req_t              req_i,
  input  logic [twp_pkg::DEN_W-1:0]      rem_i,
  input  logic [NW-1:0]                  num_i,
  input  logic [twp_pkg::DEN_W-1:0]      den_i,
  output logic                           done_o,
  output logic [NW-1:0]                  q_o
);
  import twp_pkg::*;

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NW-1:0]    num_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   r2, diff;
  logic             ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    r2   = {rem_q, num_q[NW-1]};
    diff = r2 - {1'b0, den_q};
    ge   = r2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= rem_i;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

// ===== rtl/core/twp_sqrt.sv =====
module twp_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [twp_pkg::RAD_W-1:0]     rad_i,
  output logic                          done_o,
  output logic [twp_pkg::ROOT_W-1:0]    root_o
);
  import twp_pkg::*;

  localparam int unsigned RW = 2 * ROOT_W;
  localparam int unsigned MW = ROOT_W + 4;

  logic [RW-1:0]     rad_q;
  logic [MW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [MW-1:0]     r2, trial;
  logic              ge;

  // Two radicand bits in, one root bit out per cycle
  always_comb begin
    r2    = {rem_q[MW-3:0], rad_q[RW-1:RW-2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = r2 >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RW-RAD_W){1'b0}}, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (r2 - trial) : r2;
      root_q <= {root_q[ROOT_W-2:0], ge};
      rad_q  <= rad_q << 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/tween_loop_pingpong.sv =====
// Channel  Dir  tdata (low bit up)                                   tuser
// s_axis   in   target_x, target_y, target_z, duration, loop_count,  mode
//               ping_pong, ease, tick_time, zero pad to 160
// m_axis   out  pos_x, pos_y, pos_z, busy_res, fraction_done,        -
//               zero pad to 120
// One item at a time; a result register lets the next item enter while a result waits.
// Start, stop and idle ticks need at most the fraction divide (16 steps).
// Moving tick: divide for t, t^2 and t^3 for smoothstep only, three blends on the
// bit-serial multiplier (t^2, t^3, three blends), then the fraction divide.
// Start with a speed: three 32-step squares, 34-step root, (34+FRAC_BITS)-step divide.
// Reset clears all state to zero, idle; no clearing pass.
module tween_loop_pingpong #(
  parameter int unsigned FRAC_BITS = twp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // target_x, target_y, target_z, duration, loop_count, ping_pong, ease, tick_time
  input  logic [twp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // mode
  input  logic [twp_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pos_x, pos_y, pos_z, busy_res, fraction_done
  output logic [twp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import twp_pkg::*;

  localparam int unsigned NW = ROOT_W + FRAC_BITS;
  localparam logic [CNT_W-1:0] F_CNT  = CNT_W'(FRAC_BITS);
  localparam logic [CNT_W-1:0] B_CNT  = CNT_W'(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] SQ_CNT = CNT_W'(COORD_W);
  localparam logic [CNT_W-1:0] P_CNT  = CNT_W'(NW);
  localparam logic [CNT_W-1:0] FD_CNT = CNT_W'(FRAC_DONE_BITS);
  localparam logic [FRAC_BITS+2:0] S_ONE = (FRAC_BITS+3)'(1) << FRAC_BITS;
  localparam logic [FRAC_DONE_W-1:0] FD_ONE = FRAC_DONE_W'(1) << FRAC_DONE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQ_W, ST_ROOT_W, ST_PDIV_W, ST_TICK, ST_TDIV_W,
    ST_T2_W, ST_T3_W, ST_BLEND, ST_BL_W, ST_FRAC, ST_FDIV_W, ST_OUT
  } state_e;

  state_e state_q;

  // Architectural state
  logic signed [COORD_W-1:0] pos_q [3];
  logic signed [COORD_W-1:0] start_q [3];
  logic signed [COORD_W-1:0] end_q [3];
  logic [TIME_W-1:0]         period_q, elapsed_q;
  logic signed [LOOP_W-1:0]  loops_q;
  logic                      rev_q, smooth_q, moving_q;

  // Per-item working registers
  logic signed [COORD_W-1:0] tgt_q [3];
  logic [TIME_W-1:0]         speed_q;
  logic signed [LOOP_W-1:0]  loops_in_q;
  logic                      pp_q, ease_q;
  logic [1:0]                axis_q;
  logic [RAD_W-1:0]          nsum_q;
  logic [FRAC_BITS-1:0]      t_q, t2_q;
  logic [FRAC_BITS:0]        s_q;
  logic [FRAC_DONE_W-1:0]    frac_q;
  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q;

  // Unit requests
  mul_req_t                  mul_req_q;
  logic signed [MUL_AW-1:0]  mul_a_q;
  logic [MUL_BW-1:0]         mul_b_q;
  div_req_t                  div_req_q;
  logic [DEN_W-1:0]          div_rem_q, div_den_q;
  logic [NW-1:0]             div_num_q;
  logic                      sqrt_start_q;

  logic                      mul_done, div_done, sqrt_done;
  logic signed [MUL_PW-1:0]  mul_p;
  logic [NW-1:0]             div_q;
  logic [ROOT_W-1:0]         sqrt_root;

  twp_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  twp_div #(.NW(NW)) u_div (
    .clk_i, .rst_ni, .req_i(div_req_q), .rem_i(div_rem_q), .num_i(div_num_q),
    .den_i(div_den_q), .done_o(div_done), .q_o(div_q)
  );

  twp_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start_q), .rad_i(nsum_q),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  // Input fields
  logic signed [COORD_W-1:0] in_tgt [3];
  logic signed [TIME_W-1:0]  in_dur;
  logic [TICK_W-1:0]         in_tick;
  logic                      in_acc;

  assign in_tgt[0] = s_axis_tdata_i[TGT_X_LSB +: COORD_W];
  assign in_tgt[1] = s_axis_tdata_i[TGT_Y_LSB +: COORD_W];
  assign in_tgt[2] = s_axis_tdata_i[TGT_Z_LSB +: COORD_W];
  assign in_dur    = s_axis_tdata_i[DUR_LSB +: TIME_W];
  assign in_tick   = s_axis_tdata_i[TICK_LSB +: TICK_W];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  // Datapath helpers
  logic [TIME_W:0]           el_sum;
  logic [TIME_W-1:0]         el_sat;
  logic [COORD_W:0]          sq_d, sq_neg;
  logic [COORD_W-1:0]        sq_mag;
  logic [COORD_W:0]          bl_d;
  logic signed [MUL_PW-1:0]  bl_shift;
  logic [MUL_PW-1:0]         bl_sum;
  logic [FRAC_BITS-1:0]      tp_w;
  logic [FRAC_BITS+2:0]      s3;
  logic [FRAC_BITS:0]        s_clamp;
  logic [TIME_W-1:0]         per_sat;

  always_comb begin
    el_sum   = {1'b0, elapsed_q} + {{(TIME_W+1-TICK_W){1'b0}}, in_tick};
    el_sat   = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
    sq_d     = {tgt_q[axis_q][COORD_W-1], tgt_q[axis_q]}
             - {pos_q[axis_q][COORD_W-1], pos_q[axis_q]};
    sq_neg   = ~sq_d + (COORD_W+1)'(1);
    sq_mag   = sq_d[COORD_W] ? sq_neg[COORD_W-1:0] : sq_d[COORD_W-1:0];
    bl_d     = {end_q[axis_q][COORD_W-1], end_q[axis_q]}
             - {start_q[axis_q][COORD_W-1], start_q[axis_q]};
    bl_shift = mul_p >>> FRAC_BITS;
    bl_sum   = {{(MUL_PW-COORD_W){start_q[axis_q][COORD_W-1]}}, start_q[axis_q]}
             + bl_shift;
    tp_w     = mul_p[2*FRAC_BITS-1:FRAC_BITS];
    // smoothstep 3*t2 - 2*t3 from registered t2 and fresh t3
    s3       = ({3'b000, t2_q} << 1) + {3'b000, t2_q} - ({3'b000, tp_w} << 1);
    if (s3[FRAC_BITS+2])  s_clamp = '0;
    else if (s3 > S_ONE)  s_clamp = S_ONE[FRAC_BITS:0];
    else                  s_clamp = s3[FRAC_BITS:0];
    per_sat  = (|div_q[NW-1:TIME_W]) ? '1 : div_q[TIME_W-1:0];
  end

  // Sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int k = 0; k < 3; k++) begin
        pos_q[k]   <= '0;
        start_q[k] <= '0;
        end_q[k]   <= '0;
        tgt_q[k]   <= '0;
      end
      period_q     <= '0;
      elapsed_q    <= '0;
      loops_q      <= '0;
      rev_q        <= 1'b0;
      smooth_q     <= 1'b0;
      moving_q     <= 1'b0;
      speed_q      <= '0;
      loops_in_q   <= '0;
      pp_q         <= 1'b0;
      ease_q       <= 1'b0;
      axis_q       <= '0;
      nsum_q       <= '0;
      t_q          <= '0;
      t2_q         <= '0;
      s_q          <= '0;
      frac_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      mul_req_q    <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      div_req_q    <= '0;
      div_rem_q    <= '0;
      div_den_q    <= '0;
      div_num_q    <= '0;
      sqrt_start_q <= 1'b0;
    end else begin
      mul_req_q.start <= 1'b0;
      div_req_q.start <= 1'b0;
      sqrt_start_q    <= 1'b0;
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            for (int k = 0; k < 3; k++) tgt_q[k] <= in_tgt[k];
            speed_q    <= ~in_dur + TIME_W'(1);
            loops_in_q <= s_axis_tdata_i[LOOP_LSB +: LOOP_W];
            pp_q       <= s_axis_tdata_i[PP_BIT];
            ease_q     <= s_axis_tdata_i[EASE_BIT];
            axis_q     <= '0;
            nsum_q     <= '0;
            state_q    <= ST_FRAC;
            priority if (s_axis_tuser_i == MODE_START) begin
              if (in_dur == '0) begin
                moving_q <= 1'b0;
                for (int k = 0; k < 3; k++) pos_q[k] <= in_tgt[k];
              end else if (in_dur[TIME_W-1]) begin
                state_q <= ST_SQ;
              end else begin
                period_q  <= in_dur;
                smooth_q  <= s_axis_tdata_i[EASE_BIT];
                loops_q   <= s_axis_tdata_i[LOOP_LSB +: LOOP_W];
                rev_q     <= s_axis_tdata_i[PP_BIT];
                for (int k = 0; k < 3; k++) begin
                  start_q[k] <= pos_q[k];
                  end_q[k]   <= in_tgt[k];
                end
                elapsed_q <= '0;
                moving_q  <= 1'b1;
              end
            end else if (s_axis_tuser_i == MODE_STOP) begin
              moving_q <= 1'b0;
            end else if (s_axis_tuser_i == MODE_TICK && moving_q) begin
              elapsed_q <= el_sat;
              state_q   <= ST_TICK;
            end else begin
              // idle tick or unused mode: only report the state
            end
          end
        end

        // Squared distance, one axis per multiply
        ST_SQ: begin
          mul_req_q <= '{start: 1'b1, nbits: SQ_CNT};
          mul_a_q   <= {2'b00, sq_mag};
          mul_b_q   <= sq_mag;
          state_q   <= ST_SQ_W;
        end
        ST_SQ_W: begin
          if (mul_done) begin
            nsum_q <= nsum_q + mul_p[RAD_W-1:0];
            if (axis_q == LAST_AXIS) begin
              sqrt_start_q <= 1'b1;
              state_q      <= ST_ROOT_W;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_SQ;
            end
          end
        end
        ST_ROOT_W: begin
          if (sqrt_done) begin
            div_req_q <= '{start: 1'b1, steps: P_CNT};
            div_rem_q <= '0;
            div_num_q <= {sqrt_root, {FRAC_BITS{1'b0}}};
            div_den_q <= speed_q;
            state_q   <= ST_PDIV_W;
          end
        end
        ST_PDIV_W: begin
          if (div_done) begin
            period_q  <= per_sat;
            smooth_q  <= ease_q;
            loops_q   <= loops_in_q;
            rev_q     <= pp_q;
            for (int k = 0; k < 3; k++) begin
              start_q[k] <= pos_q[k];
              end_q[k]   <= tgt_q[k];
            end
            elapsed_q <= '0;
            moving_q  <= 1'b1;
            state_q   <= ST_FRAC;
          end
        end

        // End of run, with repeat handling, or blend fraction divide
        ST_TICK: begin
          if (elapsed_q >= period_q) begin
            for (int k = 0; k < 3; k++) pos_q[k] <= end_q[k];
            moving_q <= 1'b0;
            if (loops_q != '0) begin
              if (!loops_q[LOOP_W-1]) loops_q <= loops_q - LOOP_W'(1);
              if (rev_q) begin
                if (period_q == '0) begin
                  for (int k = 0; k < 3; k++) pos_q[k] <= start_q[k];
                end else begin
                  for (int k = 0; k < 3; k++) begin
                    start_q[k] <= end_q[k];
                    end_q[k]   <= start_q[k];
                  end
                  elapsed_q <= '0;
                  moving_q  <= 1'b1;
                end
              end else if (period_q != '0) begin
                for (int k = 0; k < 3; k++) pos_q[k] <= start_q[k];
                elapsed_q <= '0;
                moving_q  <= 1'b1;
              end
            end
            state_q <= ST_FRAC;
          end else begin
            div_req_q <= '{start: 1'b1, steps: F_CNT};
            div_rem_q <= elapsed_q;
            div_num_q <= '0;
            div_den_q <= period_q;
            state_q   <= ST_TDIV_W;
          end
        end
        ST_TDIV_W: begin
          if (div_done) begin
            t_q    <= div_q[FRAC_BITS-1:0];
            axis_q <= '0;
            if (smooth_q) begin
              mul_req_q <= '{start: 1'b1, nbits: F_CNT};
              mul_a_q   <= MUL_AW'(div_q[FRAC_BITS-1:0]);
              mul_b_q   <= MUL_BW'(div_q[FRAC_BITS-1:0]);
              state_q   <= ST_T2_W;
            end else begin
              s_q     <= {1'b0, div_q[FRAC_BITS-1:0]};
              state_q <= ST_BLEND;
            end
          end
        end
        ST_T2_W: begin
          if (mul_done) begin
            t2_q      <= tp_w;
            mul_req_q <= '{start: 1'b1, nbits: F_CNT};
            mul_a_q   <= MUL_AW'(tp_w);
            mul_b_q   <= MUL_BW'(t_q);
            state_q   <= ST_T3_W;
          end
        end
        ST_T3_W: begin
          if (mul_done) begin
            s_q     <= s_clamp;
            state_q <= ST_BLEND;
          end
        end

        // Per-axis blend start + (end - start) * s
        ST_BLEND: begin
          mul_req_q <= '{start: 1'b1, nbits: B_CNT};
          mul_a_q   <= {bl_d[COORD_W], bl_d};
          mul_b_q   <= MUL_BW'(s_q);
          state_q   <= ST_BL_W;
        end
        ST_BL_W: begin
          if (mul_done) begin
            pos_q[axis_q] <= bl_sum[COORD_W-1:0];
            if (axis_q == LAST_AXIS) begin
              state_q <= ST_FRAC;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_BLEND;
            end
          end
        end

        // Reported fraction, Q1.16
        ST_FRAC: begin
          if (period_q == '0) begin
            frac_q  <= '0;
            state_q <= ST_OUT;
          end else if (elapsed_q >= period_q) begin
            frac_q  <= FD_ONE;
            state_q <= ST_OUT;
          end else begin
            div_req_q <= '{start: 1'b1, steps: FD_CNT};
            div_rem_q <= elapsed_q;
            div_num_q <= '0;
            div_den_q <= period_q;
            state_q   <= ST_FDIV_W;
          end
        end
        ST_FDIV_W: begin
          if (div_done) begin
            frac_q  <= {1'b0, div_q[FRAC_DONE_BITS-1:0]};
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{(OUT_DATA_W-3*COORD_W-1-FRAC_DONE_W){1'b0}},
                            frac_q, moving_q, pos_q[2], pos_q[1], pos_q[0]};
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken again right after accept");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_SQ_W || state_q == ST_T2_W ||
                  state_q == ST_T3_W || state_q == ST_BL_W))
    else $error("multiplier finished outside a wait state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_TDIV_W || state_q == ST_PDIV_W ||
                  state_q == ST_FDIV_W))
    else $error("divider finished outside a wait state");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[3*COORD_W+1 +: FRAC_DONE_W] <= FD_ONE))
    else $error("fraction above one");
`endif

endmodule
